[src/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while dis is high
`define ASSERT_IMPLY(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while dis is high
`define ASSERT_NEXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/wpdf_pkg.sv]
// shared constants and types for the phase difference to frequency block
`default_nettype none

package wpdf_pkg;

  localparam int CORDIC_STEPS   = 32;
  localparam int CORDIC_LATENCY = CORDIC_STEPS + 1;
  localparam int TURN_WIDTH     = 32;
  localparam int PRESCALE_SHIFT = 16;
  localparam int GUARD_BITS     = 3;
  localparam int FREQ_WIDTH     = 32;
  localparam int CFG_WIDTH      = 32;

  typedef logic [TURN_WIDTH-1:0] turn_t;
  typedef logic [FREQ_WIDTH-1:0] freq_t;
  typedef logic [CFG_WIDTH-1:0]  cfg_t;

  localparam cfg_t  CFG_RESET = 32'h0001_0000;
  localparam turn_t HALF_TURN = 32'h8000_0000;
  localparam freq_t FREQ_MAX  = 32'h7FFF_FFFF;
  localparam freq_t FREQ_MIN  = 32'h8000_0000;

  // arctangent of 2^-i in binary turns
  localparam turn_t ATAN_TABLE [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

`default_nettype wire

[src/wpdf_cordic.sv]
// pipelined vectoring cordic, one iteration per register stage
`default_nettype none

module wpdf_cordic #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic signed [SAMPLE_WIDTH-1:0] re,
  input  wire logic signed [SAMPLE_WIDTH-1:0] im,
  output wpdf_pkg::turn_t                     angle
);

  localparam int XY_WIDTH = SAMPLE_WIDTH + wpdf_pkg::PRESCALE_SHIFT + wpdf_pkg::GUARD_BITS;
  localparam int STEPS    = wpdf_pkg::CORDIC_STEPS;

  logic signed [XY_WIDTH-1:0] re_ext;
  logic signed [XY_WIDTH-1:0] im_ext;
  logic signed [XY_WIDTH-1:0] x [STEPS+1];
  logic signed [XY_WIDTH-1:0] y [STEPS+1];
  wpdf_pkg::turn_t            acc [STEPS+1];
  logic [STEPS:0]             zero;

  assign re_ext = {{(XY_WIDTH-SAMPLE_WIDTH){re[SAMPLE_WIDTH-1]}}, re}
                  <<< wpdf_pkg::PRESCALE_SHIFT;
  assign im_ext = {{(XY_WIDTH-SAMPLE_WIDTH){im[SAMPLE_WIDTH-1]}}, im}
                  <<< wpdf_pkg::PRESCALE_SHIFT;

  // fold left half plane onto the right one
  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (re == '0) && (im == '0);
      if (re_ext < 0) begin
        x[0]   <= -re_ext;
        y[0]   <= -im_ext;
        acc[0] <= wpdf_pkg::HALF_TURN;
      end else begin
        x[0]   <= re_ext;
        y[0]   <= im_ext;
        acc[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        zero[i+1] <= zero[i];
        if (y[i] >= 0) begin
          x[i+1]   <= x[i] + (y[i] >>> i);
          y[i+1]   <= y[i] - (x[i] >>> i);
          acc[i+1] <= acc[i] + wpdf_pkg::ATAN_TABLE[i];
        end else begin
          x[i+1]   <= x[i] - (y[i] >>> i);
          y[i+1]   <= y[i] + (x[i] >>> i);
          acc[i+1] <= acc[i] - wpdf_pkg::ATAN_TABLE[i];
        end
      end
    end
  end

  assign angle = zero[STEPS] ? '0 : acc[STEPS];

endmodule

`default_nettype wire

[src/wpdf_scale.sv]
// angle difference, rounding, scaling by inverse echo time and saturation
`default_nettype none

module wpdf_scale #(
  parameter int ANGLE_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire wpdf_pkg::turn_t         angle_full,
  input  wire wpdf_pkg::turn_t         angle_low,
  input  wire wpdf_pkg::cfg_t          inverse_echo_time,
  output logic                         out_valid,
  output wpdf_pkg::freq_t              frequency,
  output logic [ANGLE_WIDTH-1:0]       wrapped_angle
);

  localparam int PROD_WIDTH = ANGLE_WIDTH + wpdf_pkg::CFG_WIDTH + 1;
  localparam int TW         = wpdf_pkg::TURN_WIDTH;

  wpdf_pkg::turn_t               diff;
  wpdf_pkg::turn_t               rounded;
  logic                          valid_a;
  logic signed [ANGLE_WIDTH-1:0] angle_a;
  logic signed [wpdf_pkg::CFG_WIDTH:0] iet_s;
  logic                          valid_b;
  logic signed [ANGLE_WIDTH-1:0] angle_b;
  logic signed [PROD_WIDTH-1:0]  prod;
  logic signed [PROD_WIDTH-1:0]  prod_rnd;
  logic signed [PROD_WIDTH-1:0]  scaled;
  logic                          overflow;

  assign diff    = angle_full - angle_low;
  assign rounded = diff + (wpdf_pkg::turn_t'(1) << (TW - 1 - ANGLE_WIDTH));
  assign iet_s   = signed'({1'b0, inverse_echo_time});

  assign prod_rnd = prod + (PROD_WIDTH'(1) << (ANGLE_WIDTH - 1));
  assign scaled   = prod_rnd >>> ANGLE_WIDTH;
  assign overflow = scaled[PROD_WIDTH-1:wpdf_pkg::FREQ_WIDTH-1]
                    != {(PROD_WIDTH-wpdf_pkg::FREQ_WIDTH+1){scaled[PROD_WIDTH-1]}};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid_a   <= in_valid;
      valid_b   <= valid_a;
      out_valid <= valid_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_a       <= rounded[TW-1 -: ANGLE_WIDTH];
      angle_b       <= angle_a;
      prod          <= angle_a * iet_s;
      wrapped_angle <= angle_b;
      if (overflow) begin
        frequency <= scaled[PROD_WIDTH-1] ? wpdf_pkg::FREQ_MIN : wpdf_pkg::FREQ_MAX;
      end else begin
        frequency <= scaled[wpdf_pkg::FREQ_WIDTH-1:0];
      end
    end
  end

endmodule

`default_nettype wire

[src/wrapped_phase_difference_to_freq_top.sv]
// top level: wrapped phase difference of two complex samples scaled to frequency
//
// s_* carries one voxel per request: full and low-pass complex samples.
// m_* returns one result per voxel, in order: frequency (signed Q16.16,
// saturated) and the wrapped angle (2^(ANGLE_WIDTH-1) equals pi).
// cfg_* writes the inverse echo time (unsigned Q16.16); cfg_ready is always
// high and writes belong between bursts, with the pipeline empty.
// From accepted request to m_tvalid a voxel passes one fold stage and
// 32 cordic iteration stages, then difference, multiply and saturate stages.
// Throughput is one voxel per cycle while m_* is not stalled; both samples run through parallel cordics.
// Reset clears all valid bits and sets the inverse echo time to 1.0.
// The whole pipeline advances only while the output register is empty or
// being taken; a stalled receiver holds m_tdata and drops s_tready, so no
// request is lost or repeated.
`default_nettype none

module wrapped_phase_difference_to_freq_top #(
  parameter  int SAMPLE_WIDTH = 24,
  parameter  int ANGLE_WIDTH  = 16,
  localparam int IN_WIDTH     = ((4 * SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_WIDTH    = ((wpdf_pkg::FREQ_WIDTH + ANGLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // full_real, full_imag, low_real, low_imag
  input  wire logic [IN_WIDTH-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // frequency, wrapped_angle
  output logic [OUT_WIDTH-1:0]      m_tdata,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire wpdf_pkg::cfg_t       cfg_data
);

  localparam int LAT = wpdf_pkg::CORDIC_LATENCY;

  logic                          en;
  logic [LAT-1:0]                cordic_valid;
  wpdf_pkg::cfg_t                inverse_echo_time;
  wpdf_pkg::turn_t               angle_full;
  wpdf_pkg::turn_t               angle_low;
  wpdf_pkg::freq_t               frequency;
  logic [ANGLE_WIDTH-1:0]        wrapped_angle;
  logic signed [SAMPLE_WIDTH-1:0] full_real;
  logic signed [SAMPLE_WIDTH-1:0] full_imag;
  logic signed [SAMPLE_WIDTH-1:0] low_real;
  logic signed [SAMPLE_WIDTH-1:0] low_imag;

  assign full_real = s_tdata[0*SAMPLE_WIDTH +: SAMPLE_WIDTH];
  assign full_imag = s_tdata[1*SAMPLE_WIDTH +: SAMPLE_WIDTH];
  assign low_real  = s_tdata[2*SAMPLE_WIDTH +: SAMPLE_WIDTH];
  assign low_imag  = s_tdata[3*SAMPLE_WIDTH +: SAMPLE_WIDTH];

  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;
  assign m_tdata   = OUT_WIDTH'({wrapped_angle, frequency});

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_echo_time <= wpdf_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      inverse_echo_time <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cordic_valid <= '0;
    end else if (en) begin
      cordic_valid <= {cordic_valid[LAT-2:0], s_tvalid};
    end
  end

  wpdf_cordic #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_cordic_full (
    .clk  (clk),
    .en   (en),
    .re   (full_real),
    .im   (full_imag),
    .angle(angle_full)
  );

  wpdf_cordic #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_cordic_low (
    .clk  (clk),
    .en   (en),
    .re   (low_real),
    .im   (low_imag),
    .angle(angle_low)
  );

  wpdf_scale #(
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_scale (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .in_valid         (cordic_valid[LAT-1]),
    .angle_full       (angle_full),
    .angle_low        (angle_low),
    .inverse_echo_time(inverse_echo_time),
    .out_valid        (m_tvalid),
    .frequency        (frequency),
    .wrapped_angle    (wrapped_angle)
  );

endmodule

`default_nettype wire

[src/wpdf_checker.sv]
// port-level checker for the phase difference to frequency block, with bind
`default_nettype none
`include "assert_macros.svh"

module wpdf_checker #(
  parameter  int SAMPLE_WIDTH = 24,
  parameter  int ANGLE_WIDTH  = 16,
  localparam int IN_WIDTH     = ((4 * SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_WIDTH    = ((wpdf_pkg::FREQ_WIDTH + ANGLE_WIDTH + 7) / 8) * 8
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic [IN_WIDTH-1:0]  s_tdata,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [OUT_WIDTH-1:0] m_tdata,
  input wire logic                 cfg_valid,
  input wire logic                 cfg_ready,
  input wire wpdf_pkg::cfg_t       cfg_data
);

  localparam int FW = wpdf_pkg::FREQ_WIDTH;

  logic                   busy_in;
  logic                   cfg_seen;
  logic                   ready_cause;
  logic                   out_stall;
  logic                   freq_nonpos;
  wpdf_pkg::freq_t        freq;
  logic [ANGLE_WIDTH-1:0] angle;

  assign busy_in     = s_tvalid && (s_tdata != '0);
  assign cfg_seen    = cfg_valid && cfg_ready && (cfg_data != '0);
  assign freq        = m_tdata[FW-1:0];
  assign angle       = m_tdata[FW +: ANGLE_WIDTH];
  assign ready_cause = !m_tvalid || m_tready || busy_in || cfg_seen;
  assign out_stall   = m_tvalid && !m_tready;
  assign freq_nonpos = freq[FW-1] || (freq == '0);

  `ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_tvalid)
  `ASSERT_IMPLY(a_ready_when_free, clk, rst, ready_cause, s_tready || out_stall)
  `ASSERT_NEXT(a_hold_on_stall, clk, rst, out_stall, m_tvalid && $stable(m_tdata))
  `ASSERT_IMPLY(a_zero_angle_zero_freq, clk, rst, m_tvalid && (angle == '0), freq == '0)
  `ASSERT_IMPLY(a_negative_angle_sign, clk, rst, m_tvalid && angle[ANGLE_WIDTH-1], freq_nonpos)

endmodule

bind wrapped_phase_difference_to_freq_top wpdf_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH),
  .ANGLE_WIDTH (ANGLE_WIDTH)
) u_wpdf_checker (.*);

`default_nettype wire
